/* src/m3i_pkg.sv */
package m3i_pkg;

    // Default number of fraction bits in every fixed-point word.
    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam int unsigned Q_W    = 32;
    localparam int unsigned TOL_W  = 16;
    localparam int unsigned N_ELEM = 9;
    localparam int unsigned N_ROW  = 3;

    // Width of the common saturation input; every wide intermediate fits in it.
    localparam int unsigned SAT_W = 68;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef struct packed {
        logic signed [Q_W-1:0] a00;
        logic signed [Q_W-1:0] a01;
        logic signed [Q_W-1:0] a02;
        logic signed [Q_W-1:0] a10;
        logic signed [Q_W-1:0] a11;
        logic signed [Q_W-1:0] a12;
        logic signed [Q_W-1:0] a20;
        logic signed [Q_W-1:0] a21;
        logic signed [Q_W-1:0] a22;
    } t_m3i_in;

    typedef struct packed {
        logic signed [Q_W-1:0] b00;
        logic signed [Q_W-1:0] b01;
        logic signed [Q_W-1:0] b02;
        logic signed [Q_W-1:0] b10;
        logic signed [Q_W-1:0] b11;
        logic signed [Q_W-1:0] b12;
        logic signed [Q_W-1:0] b20;
        logic signed [Q_W-1:0] b21;
        logic signed [Q_W-1:0] b22;
        logic                  invertible;
    } t_m3i_out;

    typedef logic [N_ELEM-1:0][Q_W-1:0] t_m3i_mat;
    typedef logic [N_ROW-1:0][Q_W-1:0]  t_m3i_row;

    typedef struct packed {
        logic valid;
        logic singular;
        logic neg;
    } t_m3i_ctl;

    typedef logic [3:0] t_idx;

    // Cofactor i is (a[P]*a[Q] - a[R]*a[S]), negated where NEG is set.
    localparam t_idx COF_P [N_ELEM] = '{4'd4, 4'd3, 4'd3, 4'd1, 4'd0, 4'd0, 4'd1, 4'd0, 4'd0};
    localparam t_idx COF_Q [N_ELEM] = '{4'd8, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd5, 4'd5, 4'd4};
    localparam t_idx COF_R [N_ELEM] = '{4'd5, 4'd5, 4'd4, 4'd2, 4'd2, 4'd1, 4'd2, 4'd2, 4'd1};
    localparam t_idx COF_S [N_ELEM] = '{4'd7, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6, 4'd4, 4'd3, 4'd3};
    localparam logic COF_NEG [N_ELEM] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    // The adjugate is the cofactor matrix transposed.
    localparam t_idx ADJ_IDX [N_ELEM] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-Q_W:0] top;
        top = v[SAT_W-1:Q_W-1];
        if ((&top) || (~|top)) begin
            sat_q = v[Q_W-1:0];
        end else if (v[SAT_W-1]) begin
            sat_q = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            sat_q = {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

endpackage

/* src/m3i_cofactor.sv */
module m3i_cofactor #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  m3i_pkg::t_m3i_in   i_mat,
    output logic               o_valid,
    output m3i_pkg::t_m3i_mat  o_cof,
    output m3i_pkg::t_m3i_row  o_row0
);
    import m3i_pkg::*;

    localparam int unsigned P_W = 2 * Q_W;
    localparam int unsigned D_W = P_W + 2;

    logic signed [Q_W-1:0] a [N_ELEM];
    logic signed [P_W-1:0] r_pq [N_ELEM];
    logic signed [P_W-1:0] r_rs [N_ELEM];
    logic signed [D_W-1:0] n_d  [N_ELEM];
    t_m3i_row              r_row1;
    t_m3i_row              r_row2;
    t_m3i_mat              r_cof;
    logic                  r_v1;
    logic                  r_v2;

    assign a[0] = i_mat.a00;
    assign a[1] = i_mat.a01;
    assign a[2] = i_mat.a02;
    assign a[3] = i_mat.a10;
    assign a[4] = i_mat.a11;
    assign a[5] = i_mat.a12;
    assign a[6] = i_mat.a20;
    assign a[7] = i_mat.a21;
    assign a[8] = i_mat.a22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: the two products of every cofactor.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_ELEM; i++) begin
            r_pq[i] <= a[COF_P[i]] * a[COF_Q[i]];
            r_rs[i] <= a[COF_R[i]] * a[COF_S[i]];
        end
        r_row1 <= {a[2], a[1], a[0]};
    end

    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            n_d[i] = D_W'(r_pq[i]) - D_W'(r_rs[i]);
            if (COF_NEG[i]) begin
                n_d[i] = -n_d[i];
            end
        end
    end

    // Stage two: difference, floor to the fraction width, clamp.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_ELEM; i++) begin
            r_cof[i] <= sat_q(SAT_W'(n_d[i] >>> FRAC_BITS));
        end
        r_row2 <= r_row1;
    end

    assign o_valid = r_v2;
    assign o_cof   = r_cof;
    assign o_row0  = r_row2;

endmodule

/* src/m3i_det.sv */
module m3i_det #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
    parameter int unsigned MAG_W     = 2 * 32 + 2 - FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  m3i_pkg::t_m3i_mat         i_cof,
    input  m3i_pkg::t_m3i_row         i_row0,
    input  logic [m3i_pkg::TOL_W-1:0] i_tol,
    output m3i_pkg::t_m3i_ctl         o_ctl,
    output logic [MAG_W-1:0]          o_mag,
    output m3i_pkg::t_m3i_mat         o_adj
);
    import m3i_pkg::*;

    localparam int unsigned P_W = 2 * Q_W;

    logic signed [P_W-1:0]   r_p [N_ROW];
    logic signed [MAG_W-1:0] r_det;
    logic [MAG_W-1:0]        n_mag;
    t_m3i_mat                r_cof3;
    t_m3i_mat                r_cof4;
    t_m3i_mat                r_adj;
    logic [MAG_W-1:0]        r_mag;
    t_m3i_ctl                r_ctl;
    logic                    r_v3;
    logic                    r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_ctl <= '0;
        end else begin
            r_v3           <= i_valid;
            r_v4           <= r_v3;
            r_ctl.valid    <= r_v4;
            r_ctl.neg      <= r_det[MAG_W-1];
            r_ctl.singular <= n_mag <= MAG_W'(i_tol);
        end
    end

    assign n_mag = r_det[MAG_W-1] ? MAG_W'(-r_det) : MAG_W'(r_det);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_ROW; i++) begin
            r_p[i] <= $signed(i_row0[i]) * $signed(i_cof[i]);
        end
        r_cof3 <= i_cof;
        // Each product is floored before the sum, which is kept at full width.
        r_det  <= MAG_W'(r_p[0] >>> FRAC_BITS) + MAG_W'(r_p[1] >>> FRAC_BITS)
                + MAG_W'(r_p[2] >>> FRAC_BITS);
        r_cof4 <= r_cof3;
        r_mag  <= n_mag;
        for (int i = 0; i < N_ELEM; i++) begin
            r_adj[i] <= r_cof4[ADJ_IDX[i]];
        end
    end

    assign o_ctl = r_ctl;
    assign o_mag = r_mag;
    assign o_adj = r_adj;

endmodule

/* src/m3i_recip.sv */
module m3i_recip #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
    parameter int unsigned MAG_W     = 2 * 32 + 2 - FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  m3i_pkg::t_m3i_ctl             i_ctl,
    input  logic [MAG_W-1:0]              i_mag,
    input  m3i_pkg::t_m3i_mat             i_adj,
    output m3i_pkg::t_m3i_ctl             o_ctl,
    output logic signed [m3i_pkg::Q_W-1:0] o_recip,
    output m3i_pkg::t_m3i_mat             o_adj
);
    import m3i_pkg::*;

    // The dividend is one in the doubled fraction format, so the quotient
    // has one bit more than twice the fraction width.
    localparam int unsigned NQ = 2 * FRAC_BITS + 1;

    t_m3i_ctl         r_ctl [NQ];
    logic [MAG_W-1:0] r_div [NQ];
    logic [MAG_W-1:0] r_rem [NQ];
    logic [NQ-1:0]    r_q   [NQ];
    t_m3i_mat         r_adj [NQ];

    logic [NQ-1:0]          q_fin;
    logic                   nz_fin;
    logic signed [NQ+1:0]   n_pos;
    logic signed [NQ+1:0]   n_val;
    t_m3i_ctl               r_ctl_o;
    logic signed [Q_W-1:0]  r_recip;
    t_m3i_mat               r_adj_o;

    genvar k;
    for (k = 0; k < NQ; k++) begin : g_stage
        logic [MAG_W-1:0] rem_in;
        logic [MAG_W-1:0] div_in;
        logic [NQ-1:0]    q_in;
        t_m3i_ctl         ctl_in;
        t_m3i_mat         adj_in;
        logic [MAG_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign div_in = i_mag;
            assign q_in   = '0;
            assign ctl_in = i_ctl;
            assign adj_in = i_adj;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign div_in = r_div[k-1];
            assign q_in   = r_q[k-1];
            assign ctl_in = r_ctl[k-1];
            assign adj_in = r_adj[k-1];
        end

        // Only the leading dividend bit is set.
        assign trial = {rem_in, (k == 0) ? 1'b1 : 1'b0};
        assign ge    = trial >= {1'b0, div_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? MAG_W'(trial - {1'b0, div_in}) : MAG_W'(trial);
            r_q[k]   <= {q_in[NQ-2:0], ge};
            r_div[k] <= div_in;
            r_adj[k] <= adj_in;
        end
    end

    // Floor division toward minus infinity for a negative determinant.
    assign q_fin  = r_q[NQ-1];
    assign nz_fin = |r_rem[NQ-1];
    assign n_pos  = $signed({2'b00, q_fin});
    assign n_val  = r_ctl[NQ-1].neg
                  ? -n_pos - $signed({{(NQ+1){1'b0}}, nz_fin})
                  : n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_o <= '0;
        end else begin
            r_ctl_o <= r_ctl[NQ-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_recip <= sat_q(SAT_W'(n_val));
        r_adj_o <= r_adj[NQ-1];
    end

    assign o_ctl   = r_ctl_o;
    assign o_recip = r_recip;
    assign o_adj   = r_adj_o;

endmodule

/* src/m3i_scale.sv */
module m3i_scale #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  m3i_pkg::t_m3i_ctl              i_ctl,
    input  logic signed [m3i_pkg::Q_W-1:0] i_recip,
    input  m3i_pkg::t_m3i_mat              i_adj,
    output logic                           o_valid,
    output m3i_pkg::t_m3i_out              o_result
);
    import m3i_pkg::*;

    localparam int unsigned P_W = 2 * Q_W;

    logic signed [P_W-1:0] r_prod [N_ELEM];
    logic signed [Q_W-1:0] n_res  [N_ELEM];
    t_m3i_ctl              r_ctl;
    logic                  r_valid;
    t_m3i_out              r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ctl   <= i_ctl;
            r_valid <= r_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_ELEM; i++) begin
            r_prod[i] <= $signed(i_adj[i]) * i_recip;
        end
    end

    // A singular matrix gives an all-zero word.
    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            n_res[i] = r_ctl.singular ? '0 : sat_q(SAT_W'(r_prod[i] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= {n_res[0], n_res[1], n_res[2], n_res[3], n_res[4],
                  n_res[5], n_res[6], n_res[7], n_res[8], !r_ctl.singular};
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

/* src/matrix3_inverse_unit.sv */
// 3x3 fixed-point matrix inverse by the adjugate.
//
// Input channel: a matrix word (nine signed elements, row-major, FRAC_BITS
// fraction bits) is taken at every rising edge where start is high and busy
// is low. Busy is low at all times outside reset, so a new word may be given
// in every cycle.
// Result channel: o_valid is high for exactly one cycle with the inverse on
// o_result. The receiver cannot hold results off, and none is needed: the
// pipeline never stalls, so one result leaves per cycle at full load.
// From the accepting edge to the edge that takes the result, a word passes the
// cofactor multipliers, the determinant sum, the reciprocal divider (one
// quotient bit per pipeline stage) and the scaling multipliers.
// Configuration: one write channel for the zero tolerance, taken when
// i_cfg_valid and o_cfg_ready are both high. It may only change while the
// pipeline is empty.
// Reset clears all valid bits and loads the tolerance with one; words in
// flight are dropped.
module matrix3_inverse_unit #(
    parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  m3i_pkg::t_m3i_in          i_matrix,
    output logic                      o_valid,
    output m3i_pkg::t_m3i_out         o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [m3i_pkg::TOL_W-1:0] i_cfg_data
);
    import m3i_pkg::*;

    // The determinant of floored Q products needs this many bits signed.
    localparam int unsigned MAG_W = 2 * Q_W + 2 - FRAC_BITS;
    localparam int unsigned LAT   = 2 * FRAC_BITS + 9;

    logic [TOL_W-1:0]      r_tol;
    logic                  cof_valid;
    t_m3i_mat              cof_mat;
    t_m3i_row              cof_row0;
    t_m3i_ctl              det_ctl;
    logic [MAG_W-1:0]      det_mag;
    t_m3i_mat              det_adj;
    t_m3i_ctl              rcp_ctl;
    logic signed [Q_W-1:0] rcp_val;
    t_m3i_mat              rcp_adj;

    // The block never pushes back except while reset is held.
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    // Stages one and two: the nine cofactors.
    m3i_cofactor #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_mat   (i_matrix),
        .o_valid (cof_valid),
        .o_cof   (cof_mat),
        .o_row0  (cof_row0)
    );

    // Stages three to five: determinant, magnitude and the singular test.
    m3i_det #(
        .FRAC_BITS(FRAC_BITS),
        .MAG_W    (MAG_W)
    ) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cof_valid),
        .i_cof   (cof_mat),
        .i_row0  (cof_row0),
        .i_tol   (r_tol),
        .o_ctl   (det_ctl),
        .o_mag   (det_mag),
        .o_adj   (det_adj)
    );

    // One pipelined restoring division per word, then the sign fix-up.
    m3i_recip #(
        .FRAC_BITS(FRAC_BITS),
        .MAG_W    (MAG_W)
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (det_ctl),
        .i_mag   (det_mag),
        .i_adj   (det_adj),
        .o_ctl   (rcp_ctl),
        .o_recip (rcp_val),
        .o_adj   (rcp_adj)
    );

    // Adjugate times reciprocal, floored and clamped into the output register.
    m3i_scale #(
        .FRAC_BITS(FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rcp_ctl),
        .i_recip  (rcp_val),
        .i_adj    (rcp_adj),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Every accepted word comes out after exactly the pipeline latency.
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted word did not come out on time");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result word without an accepted input word");

    // A singular result carries zeros on the diagonal and in b01 and b20.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.invertible) |->
            (o_result.b00 == '0 && o_result.b11 == '0 && o_result.b22 == '0
             && o_result.b01 == '0 && o_result.b20 == '0))
        else $error("singular result with nonzero elements");

    // The first cycle after reset is released never carries a result.
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule
